>>> hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_LOOK       = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // what every cell of the chain does at a clock edge
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_HEAD,
    CMD_PUSH_TAIL,
    CMD_POP_HEAD,
    CMD_POP_TAIL
  } cell_cmd_t;

endpackage

>>> hw/rtl/bounded_deque_unit.sv
`timescale 1ns / 1ps

// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// in       | in_valid, in_ready  | opcode, value
// out      | out_valid, out_ready| front_value, back_value, count, is_empty,
//          |                     | status
//
// the cell chain shifts on the accept edge, and the one-hot tail pick over the
// chain loads the output register once that register is empty or being read
// in_ready stays low from accept until the beat is in the output register, so
// a stalled output holds one finished beat plus at most one item in the cells
// reset clears occupancy, count and the direction flag; element data is not
// cleared, cells become valid as they are written

module bounded_deque_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    opcode,
  input  logic [31:0]   value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   front_value,
  output logic [31:0]   back_value,
  output logic [CW-1:0] count,
  output logic          is_empty,
  output logic [1:0]    status
);

  logic [DEPTH-1:0]      occ;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      is_tail;
  logic [DATA_WIDTH-1:0] tail_data;
  logic [DATA_WIDTH-1:0] head_data;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH+31:0] value_pad;
  logic [DATA_WIDTH+31:0] head_pad;
  logic [DATA_WIDTH+31:0] tail_pad;

  bdq_pkg::cell_cmd_t cmd;
  bdq_pkg::opcode_t   op;
  bdq_pkg::status_t   status_next;
  bdq_pkg::status_t   pend_status;

  logic          rev;
  logic          rev_next;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_next;
  logic          pend;
  logic          accept;
  logic          load;
  logic          full;
  logic          empty;

  assign in_ready = !pend;
  assign accept   = in_valid && in_ready;
  assign load     = pend && (!out_valid || out_ready);
  assign full     = occ[DEPTH-1];
  assign empty    = !occ[0];
  assign op       = bdq_pkg::opcode_t'(opcode);

  assign value_pad = {{DATA_WIDTH{1'b0}}, value};
  assign push_data = value_pad[DATA_WIDTH-1:0];

  always_comb begin
    cmd         = bdq_pkg::CMD_HOLD;
    status_next = bdq_pkg::ST_OK;
    rev_next    = rev;
    count_next  = count_q;
    if (accept) begin
      unique case (op) inside
        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_next = bdq_pkg::ST_OVERFLOW;
          end else begin
            cmd = ((op == bdq_pkg::OP_PUSH_FRONT) != rev) ? bdq_pkg::CMD_PUSH_HEAD
                                                          : bdq_pkg::CMD_PUSH_TAIL;
            count_next = count_q + CW'(1);
          end
        end
        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_next = bdq_pkg::ST_UNDERFLOW;
          end else begin
            cmd = ((op == bdq_pkg::OP_POP_FRONT) != rev) ? bdq_pkg::CMD_POP_HEAD
                                                         : bdq_pkg::CMD_POP_TAIL;
            count_next = count_q - CW'(1);
          end
        end
        bdq_pkg::OP_REVERSE: begin
          rev_next = !rev;
        end
        default: begin
          status_next = bdq_pkg::ST_OK;
        end
      endcase
    end
  end

  // cell 0 is the physical head; its left neighbor is the pushed element
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_occ;
    logic [DATA_WIDTH-1:0] prev_data;
    logic                  next_occ;
    logic [DATA_WIDTH-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_occ  = 1'b1;
      assign prev_data = push_data;
    end else begin : g_mid
      assign prev_occ  = occ[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_occ  = 1'b0;
      assign next_data = '0;
    end else begin : g_inner
      assign next_occ  = occ[i+1];
      assign next_data = cell_data[i+1];
    end

    bdq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .push_data (push_data),
      .prev_occ  (prev_occ),
      .prev_data (prev_data),
      .next_occ  (next_occ),
      .next_data (next_data),
      .occ       (occ[i]),
      .data      (cell_data[i])
    );
  end

  bdq_tail_sel #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_tail_sel (
    .occ       (occ),
    .cell_data (cell_data),
    .is_tail   (is_tail),
    .tail_data (tail_data)
  );

  assign head_data = occ[0] ? cell_data[0] : '0;
  assign head_pad  = {32'b0, head_data};
  assign tail_pad  = {32'b0, tail_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      rev       <= 1'b0;
      count_q   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rev     <= rev_next;
      count_q <= count_next;
      if (accept) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
    end
    if (load) begin
      front_value <= rev ? tail_pad[31:0] : head_pad[31:0];
      back_value  <= rev ? head_pad[31:0] : tail_pad[31:0];
      count       <= count_q;
      is_empty    <= (count_q == '0);
      status      <= pend_status;
    end
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == int'(count_q))
    else $error("element count disagrees with occupied cells");

  a_single_tail: assert property (@(posedge clk) disable iff (rst)
    $onehot0(is_tail))
    else $error("more than one tail cell");

  a_full_push_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (op == bdq_pkg::OP_PUSH_FRONT || op == bdq_pkg::OP_PUSH_BACK))
    |=> $stable(count_q))
    else $error("push on full deque changed the count");

  a_empty_pop_keeps_cells: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (op == bdq_pkg::OP_POP_FRONT || op == bdq_pkg::OP_POP_BACK))
    |=> (occ == '0))
    else $error("pop on empty deque changed occupancy");

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    (pend && !load) |=> pend)
    else $error("pending item dropped before reaching the output");

endmodule

>>> hw/rtl/bdq_cell.sv
`timescale 1ns / 1ps

module bdq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bdq_pkg::cell_cmd_t      cmd,
  input  logic [DATA_WIDTH-1:0]   push_data,
  input  logic                    prev_occ,
  input  logic [DATA_WIDTH-1:0]   prev_data,
  input  logic                    next_occ,
  input  logic [DATA_WIDTH-1:0]   next_data,
  output logic                    occ,
  output logic [DATA_WIDTH-1:0]   data
);

  logic                  occ_next;
  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    occ_next  = occ;
    data_next = data;
    unique case (cmd)
      bdq_pkg::CMD_PUSH_HEAD: begin
        occ_next  = prev_occ;
        data_next = prev_data;
      end
      bdq_pkg::CMD_PUSH_TAIL: begin
        // first free cell after the occupied run takes the new element
        occ_next = occ | prev_occ;
        if (!occ && prev_occ) begin
          data_next = push_data;
        end
      end
      bdq_pkg::CMD_POP_HEAD: begin
        occ_next  = next_occ;
        data_next = next_data;
      end
      bdq_pkg::CMD_POP_TAIL: begin
        occ_next = occ & next_occ;
      end
      default: begin
        occ_next  = occ;
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> hw/rtl/bdq_tail_sel.sv
`timescale 1ns / 1ps

module bdq_tail_sel #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic [DEPTH-1:0]      occ,
  input  logic [DATA_WIDTH-1:0] cell_data [DEPTH],
  output logic [DEPTH-1:0]      is_tail,
  output logic [DATA_WIDTH-1:0] tail_data
);

  // last occupied cell of the run is the tail
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      is_tail[i] = occ[i] & ~occ[i+1];
    end
    is_tail[DEPTH-1] = occ[DEPTH-1];
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | (cell_data[i] & {DATA_WIDTH{is_tail[i]}});
    end
  end

endmodule
